/* hdl/vblt_pkg.sv */
package vblt_pkg;

    // Widths fixed by the item and register formats.
    localparam int unsigned CmdBits    = 2;
    localparam int unsigned CfgBits    = 9;
    localparam int unsigned CfgIdxBits = 2;
    localparam int unsigned StableBits = 8;
    localparam int unsigned ViolBits   = 2;

    // Default width of the line counter and the learned blank length.
    localparam int unsigned LineBitsDefault = 16;

    // Tracking constants.
    localparam logic [CfgBits-1:0]    MaxUnderscan  = CfgBits'(10);
    localparam logic [ViolBits-1:0]   MaxViolations = ViolBits'(2);
    localparam logic [StableBits-1:0] MinStable     = StableBits'(1);

    // Request commands.
    typedef enum logic [CmdBits-1:0] {
        CMD_LINE_TICK   = 2'd0,
        CMD_FRAME_START = 2'd1,
        CMD_SOFT_RESET  = 2'd2,
        CMD_UNUSED      = 2'd3
    } t_cmd;

    // Tracking modes.
    typedef enum logic [1:0] {
        MODE_FLOAT = 2'd0,
        MODE_LOCK  = 2'd1,
        MODE_FIXED = 2'd2
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CfgIdxBits-1:0] {
        REG_VBLANK_LINES = 2'd0,
        REG_YSTART_LINE  = 2'd1,
        REG_SPARE_2      = 2'd2,
        REG_SPARE_3      = 2'd3
    } t_reg_idx;

    // Mode override that a start line write applies.
    typedef struct packed {
        logic  set;
        t_mode mode;
    } t_mode_set;

endpackage

/* hdl/vblank_lock_tracker_unit.sv */
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_cmd, i_garbage_frame, i_vblank_level
// result    o_out_valid / i_out_ready  o_leave_blank, o_mode_now
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request is taken per cycle unless a stalled result holds the input register.
// A request is held in the input register, evaluated against the tracking state, and
// its result is held in the output register while the tracking state updates.
// Reset (synchronous, active low) clears the valid flags of both registers, the tracking state and the mode.
// A stalled result holds the input register; the config port is always ready.
module vblank_lock_tracker_unit
    import vblt_pkg::*;
#(
    parameter int unsigned LINE_BITS = LineBitsDefault
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CmdBits-1:0]    i_cmd,
    input  logic                  i_garbage_frame,
    input  logic                  i_vblank_level,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_leave_blank,
    output logic [1:0]            o_mode_now,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CfgIdxBits-1:0] i_cfg_index,
    input  logic [CfgBits-1:0]    i_cfg_data
);

    logic        r_in_valid;
    t_cmd        r_cmd;
    logic        r_garbage;
    logic        r_level;
    logic        r_out_valid;
    logic        r_out_leave;
    t_mode       r_out_mode;

    logic               w_advance;
    logic [CfgBits-1:0] w_vblank_lines;
    logic [CfgBits-1:0] w_ystart_line;
    t_mode_set          w_mode_set;
    logic               w_leave;
    t_mode              w_mode_next;
    t_mode              w_mode;

    // The held request moves on whenever the output register is free or being drained.
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    vblt_cfg_regs u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_vblank_lines (w_vblank_lines),
        .o_ystart_line  (w_ystart_line),
        .o_mode_set     (w_mode_set)
    );

    vblt_track_core #(
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_advance),
        .i_cmd           (r_cmd),
        .i_garbage_frame (r_garbage),
        .i_vblank_level  (r_level),
        .i_vblank_lines  (w_vblank_lines),
        .i_ystart_line   (w_ystart_line),
        .i_mode_set      (w_mode_set),
        .o_leave_blank   (w_leave),
        .o_mode_next     (w_mode_next),
        .o_mode          (w_mode)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_garbage <= i_garbage_frame;
            r_level   <= i_vblank_level;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_leave <= w_leave;
            r_out_mode  <= w_mode_next;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_leave_blank = r_out_leave;
    assign o_mode_now    = r_out_mode;

    // A held request is never dropped while the result side stalls.
    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid)
        else $error("held request lost");

    // A soft reset outside fixed mode reports floating mode.
    a_soft_reset_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_cmd == CMD_SOFT_RESET) && (w_mode != MODE_FIXED)
        |=> (o_mode_now == MODE_FLOAT))
        else $error("soft reset left a tracking mode");

    // Only a start line write leaves fixed mode.
    a_fixed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mode == MODE_FIXED) && !w_mode_set.set |=> (w_mode == MODE_FIXED))
        else $error("fixed mode left without a config write");

    // A line end is only reported for a line tick.
    a_leave_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_cmd != CMD_LINE_TICK) |=> !o_leave_blank)
        else $error("blank end on a non-tick request");

endmodule

/* hdl/vblt_cfg_regs.sv */
module vblt_cfg_regs
    import vblt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [CfgIdxBits-1:0] i_cfg_index,
    input  logic [CfgBits-1:0] i_cfg_data,
    output logic [CfgBits-1:0] o_vblank_lines,
    output logic [CfgBits-1:0] o_ystart_line,
    output t_mode_set          o_mode_set
);

    logic [CfgBits-1:0] r_vblank_lines;
    logic [CfgBits-1:0] r_ystart_line;
    logic               w_ystart_change;

    // A start line write that changes the value also forces the mode.
    assign w_ystart_change = i_cfg_valid && (t_reg_idx'(i_cfg_index) == REG_YSTART_LINE)
                             && (i_cfg_data != r_ystart_line);
    assign o_mode_set.set  = w_ystart_change;
    assign o_mode_set.mode = (i_cfg_data != '0) ? MODE_FIXED : MODE_FLOAT;

    // Register file; writes to spare indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vblank_lines <= '0;
            r_ystart_line  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_VBLANK_LINES: r_vblank_lines <= i_cfg_data;
                REG_YSTART_LINE:  r_ystart_line  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_vblank_lines = r_vblank_lines;
    assign o_ystart_line  = r_ystart_line;

endmodule

/* hdl/vblt_track_core.sv */
module vblt_track_core
    import vblt_pkg::*;
#(
    parameter int unsigned LINE_BITS = LineBitsDefault
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  t_cmd               i_cmd,
    input  logic               i_garbage_frame,
    input  logic               i_vblank_level,
    input  logic [CfgBits-1:0] i_vblank_lines,
    input  logic [CfgBits-1:0] i_ystart_line,
    input  t_mode_set          i_mode_set,
    output logic               o_leave_blank,
    output t_mode              o_mode_next,
    output t_mode              o_mode
);

    localparam logic [LINE_BITS-1:0] LineMax = '1;

    logic [LINE_BITS-1:0]  r_line_count,  n_line_count;
    logic [LINE_BITS-1:0]  r_last_blank,  n_last_blank;
    logic [StableBits-1:0] r_stable,      n_stable;
    logic [ViolBits-1:0]   r_viol_count,  n_viol_count;
    logic                  r_violated,    n_violated;
    t_mode                 r_mode,        n_mode;

    logic [LINE_BITS-1:0] w_line_inc;
    logic [LINE_BITS-1:0] w_thresh;
    logic                 w_should;
    logic                 w_leave;
    logic                 w_lock_viol;

    // Saturating line count and the transition threshold for this tick.
    assign w_line_inc = (r_line_count == LineMax) ? r_line_count : r_line_count + 1'b1;
    assign w_thresh   = i_vblank_level ? LINE_BITS'(i_vblank_lines)
                                       : LINE_BITS'(i_vblank_lines - MaxUnderscan);

    always_comb begin
        if (i_vblank_level) begin
            w_should = (w_line_inc >= w_thresh);
        end else begin
            w_should = (i_vblank_lines >= MaxUnderscan) && (w_line_inc >= w_thresh);
        end
    end

    // Next tracking state for one request.
    always_comb begin
        n_line_count = r_line_count;
        n_last_blank = r_last_blank;
        n_stable     = r_stable;
        n_viol_count = r_viol_count;
        n_violated   = r_violated;
        n_mode       = r_mode;
        w_leave      = 1'b0;
        w_lock_viol  = 1'b0;

        unique case (i_cmd)
            CMD_LINE_TICK: begin
                n_line_count = w_line_inc;
                unique case (r_mode)
                    MODE_FLOAT: begin
                        if (w_should) begin
                            if (!i_garbage_frame && (w_line_inc == r_last_blank)) begin
                                if (r_stable != '1) begin
                                    n_stable = r_stable + 1'b1;
                                end
                            end else begin
                                n_stable = '0;
                            end
                            n_last_blank = w_line_inc;
                            w_leave      = 1'b1;
                        end
                        if (n_stable >= MinStable) begin
                            n_mode       = MODE_LOCK;
                            n_viol_count = '0;
                        end
                    end
                    MODE_LOCK: begin
                        // A frame that ends off the learned length counts once.
                        if (w_line_inc == r_last_blank) begin
                            if (w_should && !r_violated) begin
                                n_viol_count = '0;
                            end else begin
                                w_lock_viol = 1'b1;
                            end
                            w_leave = 1'b1;
                        end else if (w_should) begin
                            w_lock_viol = 1'b1;
                        end
                        if (w_lock_viol) begin
                            if (!r_violated && (r_viol_count != '1)) begin
                                n_viol_count = r_viol_count + 1'b1;
                            end
                            n_violated = 1'b1;
                        end
                        if (n_viol_count > MaxViolations) begin
                            n_mode   = MODE_FLOAT;
                            n_stable = '0;
                        end
                    end
                    default: begin
                        w_leave = (w_line_inc > LINE_BITS'(i_ystart_line));
                    end
                endcase
            end
            CMD_FRAME_START: begin
                n_line_count = '0;
                n_violated   = 1'b0;
            end
            CMD_SOFT_RESET: begin
                n_line_count = '0;
                n_last_blank = '0;
                n_stable     = '0;
                n_viol_count = '0;
                n_violated   = 1'b0;
                if (r_mode != MODE_FIXED) begin
                    n_mode = MODE_FLOAT;
                end
            end
            default: ;
        endcase
    end

    // Tracking state advances once per request; start line writes force the mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= '0;
            r_last_blank <= '0;
            r_stable     <= '0;
            r_viol_count <= '0;
            r_violated   <= 1'b0;
            r_mode       <= MODE_FLOAT;
        end else begin
            if (i_step) begin
                r_line_count <= n_line_count;
                r_last_blank <= n_last_blank;
                r_stable     <= n_stable;
                r_viol_count <= n_viol_count;
                r_violated   <= n_violated;
            end
            if (i_mode_set.set) begin
                r_mode <= i_mode_set.mode;
            end else if (i_step) begin
                r_mode <= n_mode;
            end
        end
    end

    assign o_leave_blank = w_leave;
    assign o_mode_next   = n_mode;
    assign o_mode        = r_mode;

endmodule

/* sim/vblank_lock_tracker_unit_tb.sv */
module vblank_lock_tracker_unit_tb;
    import vblt_pkg::*;

    localparam int unsigned LineBits      = LineBitsDefault;
    localparam int          PhaseCount    = 10;
    localparam int          PhaseRequests = 90;
    localparam int          QuietLimit    = 2000;
    localparam int          TailCycles    = 8;
    // Longer than the largest blank length, so a frame runs past every threshold.
    localparam int          LongFrameTicks = (1 << CfgBits) + 8;

    // One result as the tracker should report it.
    typedef struct packed {
        logic  leave;
        t_mode mode;
    } t_blank_result;

    // Tracks the blanking state alongside the block and checks what it reports.
    class vblank_tracking_scoreboard;
        logic [CfgBits-1:0]    vblank_lines;
        logic [CfgBits-1:0]    ystart_line;
        logic [LineBits-1:0]   line_count;
        logic [LineBits-1:0]   learned_length;
        logic [StableBits-1:0] stable_frames;
        logic [ViolBits-1:0]   violation_count;
        logic                  violated;
        t_mode                 mode;
        t_blank_result         results_due[$];
        int                    faults;

        function new();
            vblank_lines = '0;
            ystart_line  = '0;
            mode         = MODE_FLOAT;
            faults       = 0;
            clear_tracking();
        endfunction

        // A soft reset keeps fixed mode but drops whatever was learned.
        function void clear_tracking();
            line_count      = '0;
            learned_length  = '0;
            stable_frames   = '0;
            violation_count = '0;
            violated        = 1'b0;
            if (mode != MODE_FIXED) begin
                mode = MODE_FLOAT;
            end
        endfunction

        // Only the first break in a frame counts, and the count saturates.
        function void flag_violation();
            if (!violated && violation_count != '1) begin
                violation_count++;
            end
            violated = 1'b1;
        endfunction

        // A start line write only changes the mode when the value changes.
        function void write_reg(t_reg_idx idx, logic [CfgBits-1:0] data);
            case (idx)
                REG_VBLANK_LINES: vblank_lines = data;
                REG_YSTART_LINE: begin
                    if (data != ystart_line) begin
                        ystart_line = data;
                        mode        = (data != '0) ? MODE_FIXED : MODE_FLOAT;
                    end
                end
                default: ;
            endcase
        endfunction

        // Advance the tracking state by one request and queue the result it gives.
        function void track_request(t_cmd cmd, logic garbage, logic level);
            logic leave;
            logic reached;
            leave   = 1'b0;
            reached = 1'b0;
            case (cmd)
                CMD_LINE_TICK: begin
                    if (line_count != '1) begin
                        line_count++;
                    end
                    // Below the underscan margin a low level never reaches the threshold.
                    if (level) begin
                        reached = line_count >= LineBits'(vblank_lines);
                    end else if (vblank_lines >= MaxUnderscan) begin
                        reached = line_count >= LineBits'(vblank_lines - MaxUnderscan);
                    end
                    case (mode)
                        MODE_FLOAT: begin
                            if (reached) begin
                                if (!garbage && line_count == learned_length) begin
                                    if (stable_frames != '1) begin
                                        stable_frames++;
                                    end
                                end else begin
                                    stable_frames = '0;
                                end
                                learned_length = line_count;
                                leave          = 1'b1;
                            end
                            if (stable_frames >= MinStable) begin
                                mode            = MODE_LOCK;
                                violation_count = '0;
                            end
                        end
                        MODE_LOCK: begin
                            if (line_count == learned_length) begin
                                if (reached && !violated) begin
                                    violation_count = '0;
                                end else begin
                                    flag_violation();
                                end
                                leave = 1'b1;
                            end else if (reached) begin
                                flag_violation();
                            end
                            if (violation_count > MaxViolations) begin
                                mode          = MODE_FLOAT;
                                stable_frames = '0;
                            end
                        end
                        default: begin
                            leave = line_count > LineBits'(ystart_line);
                        end
                    endcase
                end
                CMD_FRAME_START: begin
                    line_count = '0;
                    violated   = 1'b0;
                end
                CMD_SOFT_RESET: clear_tracking();
                default: ;
            endcase
            results_due.push_back('{leave: leave, mode: mode});
        endfunction

        // Compare one delivered result with the oldest one still due.
        function void check_result(logic leave, logic [1:0] mode_now);
            t_blank_result due;
            if (results_due.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("unexpected result: leave_blank %0b mode_now %0d", leave, mode_now);
                end
                return;
            end
            due = results_due.pop_front();
            if (leave !== due.leave || mode_now !== due.mode) begin
                faults++;
                if (faults <= 10) begin
                    $display("mismatch: leave_blank exp %0b got %0b, mode_now exp %0d got %0d",
                             due.leave, leave, due.mode, mode_now);
                end
            end
        endfunction
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic [CmdBits-1:0]    i_cmd           = '0;
    logic                  i_garbage_frame = 1'b0;
    logic                  i_vblank_level  = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    logic                  o_leave_blank;
    logic [1:0]            o_mode_now;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CfgIdxBits-1:0] i_cfg_index     = '0;
    logic [CfgBits-1:0]    i_cfg_data      = '0;

    vblank_tracking_scoreboard sb;
    int                        requests_sent = 0;
    int                        quiet_cycles  = 0;
    int                        stall_left    = 0;
    bit                        tx_steady     = 1'b0;
    bit                        rx_steady     = 1'b0;

    vblank_lock_tracker_unit #(
        .LINE_BITS(LineBits)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_garbage_frame(i_garbage_frame),
        .i_vblank_level (i_vblank_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_leave_blank  (o_leave_blank),
        .o_mode_now     (o_mode_now),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Idle stretches are mostly short, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    // The result side stalls at random unless the current phase runs steady.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0) begin
                stall_left <= gap_length();
            end
        end
    end

    // Watch all three channels, feed the scoreboard and guard against a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(t_reg_idx'(i_cfg_index), i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                sb.track_request(t_cmd'(i_cmd), i_garbage_frame, i_vblank_level);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_leave_blank, o_mode_now);
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready)
                    || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QuietLimit) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // Offer one request after an optional gap and hold it until it is taken.
    task automatic send(t_cmd cmd, logic garbage, logic level);
        int gap;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 9) >= 6) begin
            gap = gap_length();
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_garbage_frame <= garbage;
        i_vblank_level  <= level;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests_sent++;
    endtask

    // Hold off new requests until every result due has been delivered.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.results_due.size() != 0);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [CfgBits-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A frame start followed by line ticks; pattern 0 keeps the level high,
    // 1 keeps it low and anything else picks it per line.
    task automatic send_frame(int len, int pattern, logic garbage);
        logic level;
        send(CMD_FRAME_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat (len) begin
            level = (pattern == 0) ? 1'b1 :
                    (pattern == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            send(CMD_LINE_TICK, garbage, level);
        end
    endtask

    // One setting of both registers, then mostly well formed frames of the
    // length that locks, with off-length frames, noise and soft resets mixed in.
    task automatic run_phase(int budget);
        int                 stop_at;
        int                 pattern;
        int                 nominal;
        int                 len;
        int                 pick;
        logic [CfgBits-1:0] lines;
        logic [CfgBits-1:0] ystart;
        case ($urandom_range(0, 5))
            0:       lines = '0;
            1:       lines = CfgBits'($urandom_range(1, 9));
            2:       lines = MaxUnderscan;
            default: lines = CfgBits'($urandom_range(11, 40));
        endcase
        case ($urandom_range(0, 7))
            0:       ystart = CfgBits'(1);
            1:       ystart = CfgBits'($urandom_range(2, 40));
            2:       ystart = '1;
            default: ystart = '0;
        endcase
        pattern = $urandom_range(0, 2);
        nominal = (pattern == 1 && lines >= MaxUnderscan) ? int'(lines - MaxUnderscan)
                                                          : int'(lines);
        if (nominal == 0) begin
            nominal = 1;
        end
        cfg_write(REG_VBLANK_LINES, lines);
        cfg_write(REG_YSTART_LINE, ystart);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        stop_at   = requests_sent + budget;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send(t_cmd'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            end else if (pick == 1) begin
                send(CMD_SOFT_RESET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick == 2) begin
                wait_drained();
            end else begin
                len = nominal;
                if ($urandom_range(0, 7) == 0) begin
                    len = $urandom_range(0, 60);
                end else if ($urandom_range(0, 3) == 0) begin
                    len = nominal - 12 + $urandom_range(0, 15);
                    if (len < 0) begin
                        len = 0;
                    end
                end
                send_frame(len, pattern, ($urandom_range(0, 7) == 0));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero blank length: a high level transitions at once, a low one never.
        cfg_write(REG_VBLANK_LINES, '0);
        cfg_write(REG_YSTART_LINE, '0);
        send(CMD_LINE_TICK, 1'b0, 1'b1);
        send(CMD_UNUSED, 1'b1, 1'b0);
        send(CMD_FRAME_START, 1'b0, 1'b1);
        send(CMD_LINE_TICK, 1'b0, 1'b1);
        send(CMD_LINE_TICK, 1'b1, 1'b0);
        send(CMD_FRAME_START, 1'b1, 1'b0);
        send(CMD_LINE_TICK, 1'b1, 1'b1);
        send(CMD_SOFT_RESET, 1'b0, 1'b1);

        // Just below the underscan margin, then just above it.
        cfg_write(REG_VBLANK_LINES, CfgBits'(9));
        send_frame(3, 1, 1'b0);
        cfg_write(REG_VBLANK_LINES, CfgBits'(12));
        send_frame(2, 1, 1'b0);

        // Fixed mode survives a soft reset; rewriting the same start line is a no-op.
        cfg_write(REG_YSTART_LINE, '1);
        send_frame(1, 0, 1'b0);
        send(CMD_SOFT_RESET, 1'b1, 1'b1);
        send(CMD_LINE_TICK, 1'b0, 1'b1);
        cfg_write(REG_YSTART_LINE, '1);
        cfg_write(REG_YSTART_LINE, CfgBits'(1));
        send_frame(2, 2, 1'b0);
        cfg_write(REG_YSTART_LINE, '0);
        cfg_write(REG_SPARE_2, '1);

        // Largest blank length and a frame that runs past it.
        cfg_write(REG_VBLANK_LINES, '1);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_frame(LongFrameTicks, 0, 1'b0);
        send(CMD_FRAME_START, 1'b0, 1'b1);
        send(CMD_LINE_TICK, 1'b0, 1'b1);

        for (int phase = 0; phase < PhaseCount; phase++) begin
            run_phase(PhaseRequests);
        end

        wait_drained();
        repeat (TailCycles) @(posedge i_clk);
        if (sb.faults == 0 && sb.results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/vblt_pkg.sv
hdl/vblt_cfg_regs.sv
hdl/vblt_track_core.sv
hdl/vblank_lock_tracker_unit.sv
sim/vblank_lock_tracker_unit_tb.sv
